FILE: rtl/dsmb_pkg.sv
package dsmb_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 3;

  localparam logic [IdxW-1:0] REG_MAIL_TO_SUB  = 3'd0;
  localparam logic [IdxW-1:0] REG_MAIL_TO_MAIN = 3'd1;
  localparam logic [IdxW-1:0] REG_FLAGS_MAIN   = 3'd2;
  localparam logic [IdxW-1:0] REG_FLAGS_SUB    = 3'd3;
  localparam logic [IdxW-1:0] REG_CONTROL      = 3'd4;
  localparam logic [IdxW-1:0] REG_AUX          = 3'd5;

  localparam logic OP_READ   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;
  localparam logic SIDE_MAIN = 1'b0;
  localparam logic SIDE_SUB  = 1'b1;

  localparam logic [DataW-1:0] CTRL_MAIN_READ_OR = 32'hf000_0102;
  localparam logic [DataW-1:0] CTRL_SUB_READ_OR  = 32'hf000_0002;
  localparam logic [DataW-1:0] CTRL_MAIN_BIT     = 32'h0000_0100;
  localparam logic [DataW-1:0] CTRL_TOGGLE_MASK  = 32'h0000_00f0;
  localparam logic [DataW-1:0] CTRL_SUB_BIT_A    = 32'h0000_0020;
  localparam logic [DataW-1:0] CTRL_SUB_BIT_B    = 32'h0000_0080;
  localparam logic [DataW-1:0] CTRL_MODE_MASK    = 32'h0000_f000;
  localparam logic [DataW-1:0] CTRL_MODE_VALUE   = 32'h0000_2000;
  localparam logic [DataW-1:0] AUX_RESET         = 32'h1d00_0060;

  typedef struct packed {
    logic             valid;
    logic             op;
    logic             side;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
  } access_t;

endpackage

FILE: rtl/dsmb_regfile.sv
module dsmb_regfile
  import dsmb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  access_t          acc,
  output logic [DataW-1:0] rd_data,
  output logic             unknown
);

  logic [DataW-1:0] mail_to_sub_r, mail_to_sub_nxt;
  logic [DataW-1:0] mail_to_main_r, mail_to_main_nxt;
  logic [DataW-1:0] flags_main_r, flags_main_nxt;
  logic [DataW-1:0] flags_sub_r, flags_sub_nxt;
  logic [DataW-1:0] control_r, control_nxt;
  logic [DataW-1:0] aux_r, aux_nxt;
  logic [DataW-1:0] ctrl_mode;
  logic [DataW-1:0] toggle;
  logic             wr;

  assign wr = acc.valid && (acc.op == OP_WRITE);

  always_comb begin
    toggle = acc.data & CTRL_TOGGLE_MASK;
    if ((acc.data & (CTRL_SUB_BIT_A | CTRL_SUB_BIT_B)) != '0) begin
      ctrl_mode = (control_r & ~CTRL_MODE_MASK) | CTRL_MODE_VALUE;
    end else begin
      ctrl_mode = control_r;
    end
  end

  always_comb begin
    mail_to_sub_nxt  = mail_to_sub_r;
    mail_to_main_nxt = mail_to_main_r;
    flags_main_nxt   = flags_main_r;
    flags_sub_nxt    = flags_sub_r;
    control_nxt      = control_r;
    aux_nxt          = aux_r;
    if (wr) begin
      case (acc.idx)
        REG_MAIL_TO_SUB: begin
          if (acc.side == SIDE_MAIN) mail_to_sub_nxt = acc.data;
        end
        REG_MAIL_TO_MAIN: begin
          if (acc.side == SIDE_SUB) mail_to_main_nxt = acc.data;
        end
        REG_FLAGS_MAIN: begin
          if (acc.side == SIDE_SUB) flags_main_nxt = flags_main_r & ~acc.data;
          else flags_main_nxt = flags_main_r | acc.data;
        end
        REG_FLAGS_SUB: begin
          if (acc.side == SIDE_SUB) flags_sub_nxt = flags_sub_r | acc.data;
          else flags_sub_nxt = flags_sub_r & ~acc.data;
        end
        REG_CONTROL: begin
          if (acc.side == SIDE_MAIN) begin
            control_nxt = (control_r & ~CTRL_MAIN_BIT) | (acc.data & CTRL_MAIN_BIT);
          end else if ((ctrl_mode & toggle) != '0) begin
            // any toggle bit already set: drop the whole group
            control_nxt = ctrl_mode & ~toggle;
          end else begin
            control_nxt = ctrl_mode | toggle;
          end
        end
        REG_AUX: aux_nxt = '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_data = '0;
    unknown = 1'b0;
    case (acc.idx)
      REG_MAIL_TO_SUB:  rd_data = mail_to_sub_r;
      REG_MAIL_TO_MAIN: rd_data = mail_to_main_r;
      REG_FLAGS_MAIN:   rd_data = flags_main_r;
      REG_FLAGS_SUB:    rd_data = flags_sub_r;
      REG_CONTROL: begin
        rd_data = control_r |
                  ((acc.side == SIDE_SUB) ? CTRL_SUB_READ_OR : CTRL_MAIN_READ_OR);
      end
      REG_AUX:          rd_data = aux_r;
      default:          unknown = 1'b1;
    endcase
    if (acc.op == OP_WRITE) rd_data = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mail_to_sub_r  <= '0;
      mail_to_main_r <= '0;
      flags_main_r   <= '0;
      flags_sub_r    <= '0;
      control_r      <= '0;
      aux_r          <= AUX_RESET;
    end else begin
      mail_to_sub_r  <= mail_to_sub_nxt;
      mail_to_main_r <= mail_to_main_nxt;
      flags_main_r   <= flags_main_nxt;
      flags_sub_r    <= flags_sub_nxt;
      control_r      <= control_nxt;
      aux_r          <= aux_nxt;
    end
  end

  a_aux_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && acc.idx == REG_AUX) |=> (aux_r == '0))
    else $error("aux word not cleared by write");

  a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (!wr) |=> ($stable(mail_to_sub_r) && $stable(mail_to_main_r) &&
               $stable(flags_main_r) && $stable(flags_sub_r) &&
               $stable(control_r) && $stable(aux_r)))
    else $error("register changed without a write");

  a_mail_side: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && acc.side == SIDE_SUB) |=> $stable(mail_to_sub_r))
    else $error("sub side wrote its own inbound mailbox");

endmodule

FILE: rtl/dual_side_mailbox_registers.sv
// A result passes the access register acc_r and then the output registers before out_valid strobes.
// Throughput: one transaction per cycle; busy is held low, start is always taken.
// Each transaction is one read-modify-write of the register bank while it is held in acc_r.
// Results are presented for one cycle only; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and the bank registers;
// the aux word comes out of reset at 0x1d000060.
module dual_side_mailbox_registers
  import dsmb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_operation,
  input  logic             in_side,
  input  logic [IdxW-1:0]  in_reg_index,
  input  logic [DataW-1:0] in_write_data,
  output logic             out_valid,
  output logic [DataW-1:0] out_read_data,
  output logic             out_unknown_register
);

  access_t          acc_r, acc_nxt;
  logic             out_valid_r;
  logic [DataW-1:0] out_read_data_r;
  logic             out_unknown_r;
  logic [DataW-1:0] rd_data;
  logic             unknown;

  assign busy = 1'b0;

  always_comb begin
    acc_nxt.valid = start && !busy;
    acc_nxt.op    = in_operation;
    acc_nxt.side  = in_side;
    acc_nxt.idx   = in_reg_index;
    acc_nxt.data  = in_write_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r.valid <= acc_nxt.valid;
      out_valid_r <= acc_r.valid;
    end
    acc_r.op        <= acc_nxt.op;
    acc_r.side      <= acc_nxt.side;
    acc_r.idx       <= acc_nxt.idx;
    acc_r.data      <= acc_nxt.data;
    out_read_data_r <= rd_data;
    out_unknown_r   <= unknown;
  end

  dsmb_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc_r),
    .rd_data (rd_data),
    .unknown (unknown)
  );

  assign out_valid            = out_valid_r;
  assign out_read_data        = out_read_data_r;
  assign out_unknown_register = out_unknown_r;

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing two cycles after accept");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unknown_register) |-> (out_read_data == '0))
    else $error("unknown register returned data");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r.valid && acc_r.op == OP_WRITE) |=> (out_valid && out_read_data == '0))
    else $error("write returned non-zero data");

endmodule

FILE: verif/dual_side_mailbox_registers_tb.sv
module dual_side_mailbox_registers_tb;
  import dsmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomAccesses = 1300;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 8;

  typedef struct {
    logic [DataW-1:0] data;
    logic             unknown;
  } reply_t;

  class mailbox_board;
    logic [DataW-1:0] sub_mail;
    logic [DataW-1:0] main_mail;
    logic [DataW-1:0] flag_a;
    logic [DataW-1:0] flag_b;
    logic [DataW-1:0] ctrl;
    logic [DataW-1:0] aux;
    reply_t           awaited[$];
    int               failures;

    function new();
      sub_mail  = '0;
      main_mail = '0;
      flag_a    = '0;
      flag_b    = '0;
      ctrl      = '0;
      aux       = AUX_RESET;
      failures  = 0;
    endfunction

    function void note_access(logic op, logic side, logic [IdxW-1:0] idx,
                              logic [DataW-1:0] wdata);
      reply_t           reply;
      logic [DataW-1:0] toggle;
      reply.data    = '0;
      reply.unknown = (idx > REG_AUX);
      if (op == OP_WRITE) begin
        case (idx)
          REG_MAIL_TO_SUB: begin
            if (side == SIDE_MAIN) sub_mail = wdata;
          end
          REG_MAIL_TO_MAIN: begin
            if (side == SIDE_SUB) main_mail = wdata;
          end
          REG_FLAGS_MAIN: begin
            if (side == SIDE_SUB) flag_a = flag_a & ~wdata;
            else flag_a = flag_a | wdata;
          end
          REG_FLAGS_SUB: begin
            if (side == SIDE_SUB) flag_b = flag_b | wdata;
            else flag_b = flag_b & ~wdata;
          end
          REG_CONTROL: begin
            if (side == SIDE_MAIN) begin
              ctrl = (ctrl & ~CTRL_MAIN_BIT) | (wdata & CTRL_MAIN_BIT);
            end else begin
              toggle = wdata & CTRL_TOGGLE_MASK;
              if ((wdata & (CTRL_SUB_BIT_A | CTRL_SUB_BIT_B)) != '0)
                ctrl = (ctrl & ~CTRL_MODE_MASK) | CTRL_MODE_VALUE;
              // clear the group if any bit of it is set, else set it
              if ((ctrl & toggle) != '0) ctrl = ctrl & ~toggle;
              else ctrl = ctrl | toggle;
            end
          end
          REG_AUX: aux = '0;
          default: ;
        endcase
      end else begin
        case (idx)
          REG_MAIL_TO_SUB:  reply.data = sub_mail;
          REG_MAIL_TO_MAIN: reply.data = main_mail;
          REG_FLAGS_MAIN:   reply.data = flag_a;
          REG_FLAGS_SUB:    reply.data = flag_b;
          REG_CONTROL:
            reply.data = ctrl | ((side == SIDE_SUB) ? CTRL_SUB_READ_OR : CTRL_MAIN_READ_OR);
          REG_AUX:          reply.data = aux;
          default:          reply.data = '0;
        endcase
      end
      awaited.push_back(reply);
    endfunction

    function void check_result(logic [DataW-1:0] rdata, logic unknown);
      reply_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: read_data %h unknown_register %b",
               rdata, unknown);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (rdata !== want.data) begin
        $error("read_data: expected %h, actual %h", want.data, rdata);
        failures++;
      end
      if (unknown !== want.unknown) begin
        $error("unknown_register: expected %b, actual %b", want.unknown, unknown);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_operation;
  logic             in_side;
  logic [IdxW-1:0]  in_reg_index;
  logic [DataW-1:0] in_write_data;
  logic             out_valid;
  logic [DataW-1:0] out_read_data;
  logic             out_unknown_register;

  mailbox_board board = new();
  int unsigned  cycles;

  dual_side_mailbox_registers dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_side              (in_side),
    .in_reg_index         (in_reg_index),
    .in_write_data        (in_write_data),
    .out_valid            (out_valid),
    .out_read_data        (out_read_data),
    .out_unknown_register (out_unknown_register)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sample at the edge, before any update of this step lands
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_read_data, out_unknown_register);
    if (rst_n && start && !busy)
      board.note_access(in_operation, in_side, in_reg_index, in_write_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic issue(logic op, logic side, logic [IdxW-1:0] idx,
                       logic [DataW-1:0] wdata, int unsigned gap, bit drain);
    start         <= 1'b1;
    in_operation  <= op;
    in_side       <= side;
    in_reg_index  <= idx;
    in_write_data <= wdata;
    do @(posedge clk); while (busy);
    if (gap > 0 || drain) start <= 1'b0;
    // hold off until every outstanding transaction has returned
    if (drain) begin
      @(posedge clk);
      while (board.pending() != 0) @(posedge clk);
    end
    repeat (gap) @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom} & 32'h0000_01f0;
      4:       return 32'h1 << $urandom_range(0, DataW - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    bit          quiet;
    int unsigned stretch;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_READ;
    in_side       = SIDE_MAIN;
    in_reg_index  = '0;
    in_write_data = '0;
    cycles        = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, side-specific control constants, unknown indices
    issue(OP_READ,  SIDE_MAIN, REG_CONTROL,      '0,            0, 0);
    issue(OP_READ,  SIDE_SUB,  REG_CONTROL,      '0,            1, 0);
    issue(OP_READ,  SIDE_MAIN, REG_AUX,          '0,            0, 0);
    issue(OP_READ,  SIDE_SUB,  3'd6,             '0,            0, 0);
    issue(OP_READ,  SIDE_MAIN, 3'd7,             '1,            2, 0);
    // mailboxes, including writes from the wrong side
    issue(OP_WRITE, SIDE_MAIN, REG_MAIL_TO_SUB,  '1,            0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_MAIL_TO_SUB,  32'h1234_5678, 0, 0);
    issue(OP_READ,  SIDE_SUB,  REG_MAIL_TO_SUB,  '0,            0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_MAIL_TO_MAIN, '1,            0, 0);
    issue(OP_READ,  SIDE_MAIN, REG_MAIL_TO_MAIN, '0,            0, 0);
    // flag words: set from one side, clear from the other
    issue(OP_WRITE, SIDE_MAIN, REG_FLAGS_MAIN,   '1,            0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_FLAGS_MAIN,   32'h0000_ffff, 0, 0);
    issue(OP_READ,  SIDE_SUB,  REG_FLAGS_MAIN,   '0,            0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_FLAGS_SUB,    '1,            0, 0);
    issue(OP_WRITE, SIDE_MAIN, REG_FLAGS_SUB,    32'hffff_0000, 0, 0);
    issue(OP_READ,  SIDE_MAIN, REG_FLAGS_SUB,    '0,            0, 0);
    // control: main bit, mode force, group set then clear, empty group
    issue(OP_WRITE, SIDE_MAIN, REG_CONTROL,      '1,            0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_CONTROL,      32'h0000_0020, 0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_CONTROL,      32'h0000_00f0, 0, 0);
    issue(OP_WRITE, SIDE_SUB,  REG_CONTROL,      '0,            0, 0);
    issue(OP_READ,  SIDE_SUB,  REG_CONTROL,      '0,            0, 0);
    // aux cleared by any write, unknown write changes nothing
    issue(OP_WRITE, SIDE_SUB,  REG_AUX,          '0,            0, 0);
    issue(OP_READ,  SIDE_MAIN, REG_AUX,          '0,            0, 0);
    issue(OP_WRITE, SIDE_MAIN, 3'd6,             '1,            0, 0);
    issue(OP_READ,  SIDE_SUB,  REG_AUX,          '0,            0, 1);

    quiet   = 1'b0;
    stretch = 0;
    for (int unsigned n = 0; n < RandomAccesses; n++) begin
      if (stretch == 0) begin
        quiet   = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(10, 60);
      end
      stretch--;
      issue(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
            IdxW'($urandom_range(0, 7)), pick_data(), pick_gap(quiet),
            (n == RandomAccesses / 2) || (n == RandomAccesses - 1));
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.failures++;
    end
    if (board.failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/dsmb_pkg.sv
rtl/dsmb_regfile.sv
rtl/dual_side_mailbox_registers.sv
verif/dual_side_mailbox_registers_tb.sv
